// ===== rtl/differential_drive_odometry_defines.svh =====
// Shared assertion macros for the odometry block.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define ODO_ASSERT_NOW(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("odometry assertion failed");

// Check that a condition implies another in the following cycle.
`define ODO_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("odometry assertion failed");

`endif

// ===== rtl/odo_pkg.sv =====
package odo_pkg;

  // Fixed-point constants
  localparam int PI_Q16     = 205887;
  localparam int TWO_PI_Q16 = 411775;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam int DIV_STEPS = 63;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_INV_L  = 3'd0;
  localparam logic [2:0] REG_INV_R  = 3'd1;
  localparam logic [2:0] REG_RADIUS = 3'd2;
  localparam logic [2:0] REG_RCORR  = 3'd3;
  localparam logic [2:0] REG_SEP    = 3'd4;
  localparam logic [2:0] REG_SCORR  = 3'd5;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_POSE, OP_DIV_WC, OP_MUL_DL, OP_MUL_DR, OP_MUL_SL,
    OP_MUL_SR, OP_DIV_HD, OP_COR_POS, OP_MUL_X, OP_MUL_Y, OP_COR_QUAT,
    OP_DIV_ANG, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic cor_done;
    logic out_free;
  } sts_t;

  // Arctangent table, floor(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  return 30'd843314856;
      5'd1:  return 30'd497837829;
      5'd2:  return 30'd263043836;
      5'd3:  return 30'd133525158;
      5'd4:  return 30'd67021686;
      5'd5:  return 30'd33543515;
      5'd6:  return 30'd16775850;
      5'd7:  return 30'd8388437;
      5'd8:  return 30'd4194282;
      5'd9:  return 30'd2097149;
      5'd10: return 30'd1048575;
      5'd11: return 30'd524287;
      5'd12: return 30'd262143;
      5'd13: return 30'd131071;
      5'd14: return 30'd65535;
      5'd15: return 30'd32767;
      5'd16: return 30'd16383;
      5'd17: return 30'd8191;
      5'd18: return 30'd4095;
      5'd19: return 30'd2047;
      5'd20: return 30'd1023;
      5'd21: return 30'd511;
      5'd22: return 30'd255;
      5'd23: return 30'd127;
      default: return 30'd0;
    endcase
  endfunction

endpackage

// ===== rtl/odo_ctrl.sv =====
module odo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_op,
  output logic          in_tready,
  input  odo_pkg::sts_t sts,
  output odo_pkg::cmd_t cmd
);
  import odo_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_WC   = 13'b0000000000010,
    ST_MDL  = 13'b0000000000100,
    ST_MDR  = 13'b0000000001000,
    ST_MSL  = 13'b0000000010000,
    ST_MSR  = 13'b0000000100000,
    ST_DHD  = 13'b0000001000000,
    ST_CPOS = 13'b0000010000000,
    ST_MX   = 13'b0000100000000,
    ST_MY   = 13'b0001000000000,
    ST_CQ   = 13'b0010000000000,
    ST_DANG = 13'b0100000000000,
    ST_OUT  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   first_r;

  assign in_tready = (state_r == ST_IDLE);
  assign cmd.start = first_r;

  // Sequence a pose load or one tick through the datapath
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.op = in_op ? OP_POSE : OP_LOAD;
          if (!in_op) state_nxt = ST_WC;
        end
      end
      ST_WC: begin
        cmd.op = OP_DIV_WC;
        if (!first_r && sts.div_done) state_nxt = ST_MDL;
      end
      ST_MDL: begin
        cmd.op = OP_MUL_DL;
        state_nxt = ST_MDR;
      end
      ST_MDR: begin
        cmd.op = OP_MUL_DR;
        state_nxt = ST_MSL;
      end
      ST_MSL: begin
        cmd.op = OP_MUL_SL;
        state_nxt = ST_MSR;
      end
      ST_MSR: begin
        cmd.op = OP_MUL_SR;
        state_nxt = ST_DHD;
      end
      ST_DHD: begin
        cmd.op = OP_DIV_HD;
        if (!first_r && sts.div_done) state_nxt = ST_CPOS;
      end
      ST_CPOS: begin
        cmd.op = OP_COR_POS;
        if (!first_r && sts.cor_done) state_nxt = ST_MX;
      end
      ST_MX: begin
        cmd.op = OP_MUL_X;
        state_nxt = ST_MY;
      end
      ST_MY: begin
        cmd.op = OP_MUL_Y;
        state_nxt = ST_CQ;
      end
      ST_CQ: begin
        cmd.op = OP_COR_QUAT;
        if (!first_r && sts.cor_done) state_nxt = ST_DANG;
      end
      ST_DANG: begin
        cmd.op = OP_DIV_ANG;
        if (!first_r && sts.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.op = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= (state_nxt != state_r);
    end
  end

endmodule

// ===== rtl/odo_dp.sv =====
module odo_dp #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  odo_pkg::cmd_t       cmd,
  output odo_pkg::sts_t       sts,
  input  logic                invert_left,
  input  logic                invert_right,
  input  logic [15:0]         wheel_radius,
  input  logic [15:0]         radius_correction,
  input  logic [15:0]         wheel_separation,
  input  logic [15:0]         separation_correction,
  input  logic [31:0]         angle_left,
  input  logic [31:0]         angle_right,
  input  logic [31:0]         rate_left,
  input  logic [31:0]         rate_right,
  input  logic                fault_left,
  input  logic                fault_right,
  input  logic [31:0]         new_x,
  input  logic [31:0]         new_y,
  input  logic [18:0]         new_heading,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [183:0]        out_tdata
);
  import odo_pkg::*;

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // Wrap a heading once into +-pi after saturating to 20 bits
  function automatic logic signed [19:0] wrap_h(input logic signed [22:0] h);
    logic signed [22:0] c;
    c = h;
    if (h > 23'sd524287) c = 23'sd524287;
    else if (h < -23'sd524288) c = -23'sd524288;
    if (c > PI_Q16) c = c - 23'(TWO_PI_Q16);
    else if (c < -PI_Q16) c = c + 23'(TWO_PI_Q16);
    return c[19:0];
  endfunction

  // Round a Q.30 CORDIC output to Q1.16, clamp and fold back the half turn
  function automatic logic signed [17:0] cfin(input logic signed [33:0] v,
                                              input logic neg);
    logic signed [33:0] r;
    r = (v + 34'sd8192) >>> 14;
    if (r > 34'sd65536) r = 34'sd65536;
    else if (r < -34'sd65536) r = -34'sd65536;
    if (neg) r = -r;
    return r[17:0];
  endfunction

  // Pose state and wheel history
  logic [31:0]        acc_x_r, acc_y_r, last_l_r, last_r_r;
  logic signed [19:0] acc_h_r;
  logic               valid_r;

  // Per-tick working registers
  logic [31:0]        curl_r, curr_r, den_r, ang_r;
  logic signed [32:0] rl_r, rr_r;
  logic [16:0]        wc_r;
  logic signed [33:0] dl_r, dr_r, sl_r, sr_r;
  logic signed [17:0] cos_r, sin_r, qw_r, qz_r;

  // Divider
  logic [62:0] num_r, q_r;
  logic [31:0] rem_r, dvs_r;
  logic [5:0]  dcnt_r;
  logic        dbusy_r, ddone_r, dneg_r, dsat_r, dzero_r;

  // CORDIC
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [CW-1:0]      ccnt_r;
  logic               cbusy_r, cdone_r, cneg_r;

  // Output register
  logic         out_valid_r;
  logic [183:0] out_data_r;

  logic div_start, cor_start, div_fin, cor_fin;

  assign div_start = cmd.start && (cmd.op == OP_DIV_WC || cmd.op == OP_DIV_HD ||
                                   cmd.op == OP_DIV_ANG);
  assign cor_start = cmd.start && (cmd.op == OP_COR_POS || cmd.op == OP_COR_QUAT);
  assign div_fin   = !cmd.start && ddone_r;
  assign cor_fin   = !cmd.start && cdone_r;

  assign sts.div_done = ddone_r;
  assign sts.cor_done = cdone_r;
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  // Input conditioning
  logic [31:0]        curl_in, curr_in;
  logic signed [32:0] rl_in, rr_in;
  assign curl_in = invert_left  ? (32'd0 - angle_left)  : angle_left;
  assign curr_in = invert_right ? (32'd0 - angle_right) : angle_right;
  assign rl_in   = invert_left  ? -33'($signed(rate_left))  : 33'($signed(rate_left));
  assign rr_in   = invert_right ? -33'($signed(rate_right)) : 33'($signed(rate_right));

  // Shared multiplier
  logic signed [34:0] dsum, ssum, ma;
  logic signed [33:0] mean, lin_w;
  logic signed [17:0] mb;
  logic signed [52:0] mp;
  assign dsum  = 35'(dl_r) + 35'(dr_r);
  assign mean  = dsum[34:1];
  assign ssum  = 35'(sl_r) + 35'(sr_r);
  assign lin_w = ssum[34:1];

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL_DL: begin
        ma = 35'($signed(last_l_r)) - 35'($signed(curl_r));
        mb = $signed({1'b0, wc_r});
      end
      OP_MUL_DR: begin
        ma = 35'($signed(last_r_r)) - 35'($signed(curr_r));
        mb = $signed({1'b0, wc_r});
      end
      OP_MUL_SL: begin
        ma = 35'(rl_r);
        mb = $signed({1'b0, wc_r});
      end
      OP_MUL_SR: begin
        ma = 35'(rr_r);
        mb = $signed({1'b0, wc_r});
      end
      OP_MUL_X: begin
        ma = 35'(mean);
        mb = cos_r;
      end
      OP_MUL_Y: begin
        ma = 35'(mean);
        mb = sin_r;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end
  assign mp = ma * mb;

  // Divider operand setup and result shaping
  logic signed [34:0] dn;
  logic [34:0]        dm;
  logic [62:0]        cap;
  logic [31:0]        qmag;
  logic signed [32:0] qs;
  logic signed [22:0] hsum;
  logic [32:0]        dt;
  logic               dge;

  assign dn   = (cmd.op == OP_DIV_ANG) ? (35'(sl_r) - 35'(sr_r))
                                       : (35'(dl_r) - 35'(dr_r));
  assign dm   = dn[34] ? 35'(-dn) : 35'(dn);
  assign cap  = (cmd.op == OP_DIV_ANG) ? (63'd1 << 31) : (63'd1 << 20);
  assign qmag = dzero_r ? 32'd0 : ((dsat_r || q_r > cap) ? cap[31:0] : q_r[31:0]);
  assign qs   = dneg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign hsum = 23'(acc_h_r) + $signed(qs[22:0]);
  assign dt   = {rem_r, num_r[62]};
  assign dge  = dt >= {1'b0, dvs_r};

  // CORDIC start angle and step
  logic signed [33:0] hz, cz0, xs, ys, at;
  assign hz  = 34'(acc_h_r);
  assign cz0 = (cmd.op == OP_COR_POS) ? (hz <<< 14) : (hz <<< 13);
  assign xs  = cx_r >>> ccnt_r;
  assign ys  = cy_r >>> ccnt_r;
  assign at  = $signed({4'b0, atan_q30(5'(ccnt_r))});

  // Control and pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_h_r     <= '0;
      last_l_r    <= '0;
      last_r_r    <= '0;
      valid_r     <= 1'b1;
      dbusy_r     <= 1'b0;
      ddone_r     <= 1'b0;
      cbusy_r     <= 1'b0;
      cdone_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // pose and valid flag
      case (cmd.op)
        OP_POSE: begin
          acc_x_r <= new_x;
          acc_y_r <= new_y;
          acc_h_r <= wrap_h(23'($signed(new_heading)));
          valid_r <= 1'b1;
        end
        OP_LOAD: begin
          if (fault_left || fault_right) valid_r <= 1'b0;
        end
        OP_MUL_DR: begin
          last_l_r <= curl_r;
          last_r_r <= curr_r;
        end
        OP_DIV_HD: begin
          if (div_fin) acc_h_r <= wrap_h(hsum);
        end
        OP_MUL_X: acc_x_r <= acc_x_r + mp[47:16];
        OP_MUL_Y: acc_y_r <= acc_y_r + mp[47:16];
        default: ;
      endcase

      // divider control
      if (div_start) begin
        dbusy_r <= 1'b1;
        ddone_r <= 1'b0;
      end else if (dbusy_r && dcnt_r == 6'(DIV_STEPS - 1)) begin
        dbusy_r <= 1'b0;
        ddone_r <= 1'b1;
      end

      // CORDIC control
      if (cor_start) begin
        cbusy_r <= 1'b1;
        cdone_r <= 1'b0;
      end else if (cbusy_r && ccnt_r == CW'(CORDIC_STEPS - 1)) begin
        cbusy_r <= 1'b0;
        cdone_r <= 1'b1;
      end

      // result handshake
      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    den_r <= wheel_separation * separation_correction;

    case (cmd.op)
      OP_LOAD: begin
        curl_r <= curl_in;
        curr_r <= curr_in;
        rl_r   <= rl_in;
        rr_r   <= rr_in;
      end
      OP_DIV_WC:   if (div_fin) wc_r <= q_r[16:0];
      OP_MUL_DL:   dl_r <= mp[49:16];
      OP_MUL_DR:   dr_r <= mp[49:16];
      OP_MUL_SL:   sl_r <= mp[49:16];
      OP_MUL_SR:   sr_r <= mp[49:16];
      OP_DIV_ANG: begin
        if (div_fin) ang_r <= (qs == 33'sh080000000) ? 32'h7fffffff : qs[31:0];
      end
      OP_COR_POS: begin
        if (cor_fin) begin
          cos_r <= cfin(cx_r, cneg_r);
          sin_r <= cfin(cy_r, cneg_r);
        end
      end
      OP_COR_QUAT: begin
        if (cor_fin) begin
          qw_r <= cfin(cx_r, cneg_r);
          qz_r <= cfin(cy_r, cneg_r);
        end
      end
      OP_OUT: begin
        out_data_r[31:0]    <= acc_x_r;
        out_data_r[63:32]   <= acc_y_r;
        out_data_r[82:64]   <= acc_h_r[18:0];
        out_data_r[100:83]  <= qw_r;
        out_data_r[118:101] <= qz_r;
        if (lin_w > 34'sd2147483647) out_data_r[150:119] <= 32'h7fffffff;
        else if (lin_w < -34'sd2147483648) out_data_r[150:119] <= 32'h80000000;
        else out_data_r[150:119] <= lin_w[31:0];
        out_data_r[182:151] <= ang_r;
        out_data_r[183]     <= valid_r;
      end
      default: ;
    endcase

    // divider: load operands, then one quotient bit a cycle
    if (div_start) begin
      rem_r  <= '0;
      q_r    <= '0;
      dcnt_r <= '0;
      if (cmd.op == OP_DIV_WC) begin
        num_r   <= {32'd0, wheel_radius, 15'd0};
        dvs_r   <= {15'd0, 17'(radius_correction) + 17'd16384};
        dneg_r  <= 1'b0;
        dsat_r  <= 1'b0;
        dzero_r <= 1'b0;
      end else begin
        num_r   <= {dm[32:0], 30'd0};
        dvs_r   <= den_r;
        dneg_r  <= dn[34];
        dsat_r  <= |dm[34:33];
        dzero_r <= (den_r == 32'd0);
      end
    end else if (dbusy_r) begin
      rem_r  <= dge ? 32'(dt - {1'b0, dvs_r}) : dt[31:0];
      q_r    <= {q_r[61:0], dge};
      num_r  <= {num_r[61:0], 1'b0};
      dcnt_r <= dcnt_r + 6'd1;
    end

    // CORDIC: fold into the right half plane, then rotate one step a cycle
    if (cor_start) begin
      cx_r   <= GAIN_Q30;
      cy_r   <= '0;
      ccnt_r <= '0;
      if (cz0 > HALF_PI_Q30) begin
        cz_r   <= cz0 - PI_Q30;
        cneg_r <= 1'b1;
      end else if (cz0 < -HALF_PI_Q30) begin
        cz_r   <= cz0 + PI_Q30;
        cneg_r <= 1'b1;
      end else begin
        cz_r   <= cz0;
        cneg_r <= 1'b0;
      end
    end else if (cbusy_r) begin
      if (cz_r >= 0) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end
      ccnt_r <= ccnt_r + CW'(1);
    end
  end

endmodule

// ===== rtl/differential_drive_odometry.sv =====
// Differential-drive wheel odometry.
// Input stream: one item per tick or pose load; in_tuser[0] selects a tick (0)
// or a pose load (1). A pose load leaves in_tready high and gives no result.
// A tick gives one result item on the output stream: pose, half-angle
// quaternion, linear and angular speed and the sticky valid flag.
// From transfer to result valid, a tick runs three 63-step restoring
// divisions (wheel scale, heading step, angular speed) and two CORDIC passes
// on one shared unit each, plus multiplies through one shared combinational
// multiplier. in_tready is high only while no tick is in work, so one tick
// is handled at a time.
// The result sits in an output register; the next item is taken while it
// waits, and a stalled receiver only holds the block at the end of the
// following tick. Reset clears pose and stored wheel angles, drops any result,
// sets the valid flag and loads the register defaults (corrections 1.0).
// Configuration: APB registers at byte addresses 0x00..0x14; write them only
// while no tick is in work (the block itself does not enforce this).
`include "differential_drive_odometry_defines.svh"

module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // operation
  input  logic [0:0]   in_tuser,
  // angle_left, angle_right, rate_left, rate_right, fault_left, fault_right,
  // new_x, new_y, new_heading, zero fill
  input  logic [215:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, heading, quat_w, quat_z, linear_speed, angular_speed,
  // valid_res
  output logic [183:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import odo_pkg::*;

  logic        inv_l_r, inv_r_r;
  logic [15:0] radius_r, rcorr_r, sep_r, scorr_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;
  cmd_t        cmd;
  sts_t        sts;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_l_r  <= 1'b0;
      inv_r_r  <= 1'b0;
      radius_r <= '0;
      rcorr_r  <= 16'd16384;
      sep_r    <= '0;
      scorr_r  <= 16'd16384;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INV_L:  inv_l_r  <= cfg_pwdata[0];
        REG_INV_R:  inv_r_r  <= cfg_pwdata[0];
        REG_RADIUS: radius_r <= cfg_pwdata[15:0];
        REG_RCORR:  rcorr_r  <= cfg_pwdata[15:0];
        REG_SEP:    sep_r    <= cfg_pwdata[15:0];
        REG_SCORR:  scorr_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_INV_L:  cfg_prdata = {31'd0, inv_l_r};
      REG_INV_R:  cfg_prdata = {31'd0, inv_r_r};
      REG_RADIUS: cfg_prdata = {16'd0, radius_r};
      REG_RCORR:  cfg_prdata = {16'd0, rcorr_r};
      REG_SEP:    cfg_prdata = {16'd0, sep_r};
      REG_SCORR:  cfg_prdata = {16'd0, scorr_r};
      default:    cfg_prdata = '0;
    endcase
  end

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  odo_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .invert_left           (inv_l_r),
    .invert_right          (inv_r_r),
    .wheel_radius          (radius_r),
    .radius_correction     (rcorr_r),
    .wheel_separation      (sep_r),
    .separation_correction (scorr_r),
    .angle_left            (in_tdata[31:0]),
    .angle_right           (in_tdata[63:32]),
    .rate_left             (in_tdata[95:64]),
    .rate_right            (in_tdata[127:96]),
    .fault_left            (in_tdata[128]),
    .fault_right           (in_tdata[129]),
    .new_x                 (in_tdata[161:130]),
    .new_y                 (in_tdata[193:162]),
    .new_heading           (in_tdata[212:194]),
    .out_tready            (out_tready),
    .out_tvalid            (out_tvalid),
    .out_tdata             (out_tdata)
  );

  // Checks
  `ODO_ASSERT_NEXT(a_tick_blocks, clk, rst_n, in_tvalid && in_tready && !in_tuser[0], !in_tready)
  `ODO_ASSERT_NEXT(a_pose_quick, clk, rst_n, in_tvalid && in_tready && in_tuser[0], in_tready)
  `ODO_ASSERT_NOW(a_head_range, clk, rst_n, out_tvalid, ($signed(out_tdata[82:64]) <= 19'sd205887) && ($signed(out_tdata[82:64]) >= -19'sd205887))
  `ODO_ASSERT_NOW(a_quat_range, clk, rst_n, out_tvalid, ($signed(out_tdata[100:83]) <= 18'sd65536) && ($signed(out_tdata[100:83]) >= -18'sd65536))

endmodule

// ===== bench/differential_drive_odometry_tb.sv =====
module differential_drive_odometry_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import odo_pkg::*;

  // One result item, packed as on out_tdata (pos_x in the lowest bits)
  typedef struct packed {
    bit        valid_res;
    bit [31:0] angular_speed;
    bit [31:0] linear_speed;
    bit [17:0] quat_z;
    bit [17:0] quat_w;
    bit [18:0] heading;
    bit [31:0] pos_y;
    bit [31:0] pos_x;
  } pose_res_t;

  // Odometry predictor and queue of pending poses
  class odo_scoreboard;
    bit        inv_l, inv_r;
    bit [15:0] radius, rcorr, sep, scorr;
    bit [31:0] px, py, last_l, last_r;
    longint    hd;
    bit        vflag;
    pose_res_t pending_q[$];
    int        errors;

    function new();
      inv_l = 0; inv_r = 0; radius = 0; rcorr = 16384; sep = 0; scorr = 16384;
      px = 0; py = 0; hd = 0; last_l = 0; last_r = 0; vflag = 1; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, bit [15:0] v);
      case (idx)
        REG_INV_L:  inv_l  = v[0];
        REG_INV_R:  inv_r  = v[0];
        REG_RADIUS: radius = v;
        REG_RCORR:  rcorr  = v;
        REG_SEP:    sep    = v;
        REG_SCORR:  scorr  = v;
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Saturate to 20 bits, then fold once into +-pi
    function longint wrap_hd(longint h);
      h = clip(h, -524288, 524287);
      if (h > PI_Q16) h -= TWO_PI_Q16;
      else if (h < -PI_Q16) h += TWO_PI_Q16;
      return h;
    endfunction

    // Signed quotient n * 2^30 / den, magnitude capped
    function longint ratio(longint n, longint unsigned den, longint unsigned cap);
      longint unsigned m, q;
      if (den == 0) return 0;
      m = n < 0 ? -n : n;
      if (m >= 64'd1 << 33) q = cap;
      else begin
        q = (m << 30) / den;
        if (q > cap) q = cap;
      end
      return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function void sincos(longint z, output longint c, output longint s);
      longint x, y, nx, ang;
      bit     neg;
      x = GAIN_Q30; y = 0; neg = 0;
      if (z > HALF_PI_Q30) begin
        z -= PI_Q30; neg = 1;
      end else if (z < -HALF_PI_Q30) begin
        z += PI_Q30; neg = 1;
      end
      for (int i = 0; i < 16; i++) begin
        ang = atan_tab(i);
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= ang;
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += ang;
        end
        x = nx;
      end
      x = clip((x + 8192) >>> 14, -65536, 65536);
      y = clip((y + 8192) >>> 14, -65536, 65536);
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    function longint atan_tab(int i);
      longint t[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                        33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                        524287, 262143, 131071, 65535, 32767};
      return t[i];
    endfunction

    // Note an accepted input transfer
    function void note_input(bit op, bit [215:0] d);
      bit [31:0] cl, cr;
      longint    rl, rr, wc, dl, dr, mean, c, s, qc, qs, sl, sr, lin, ang;
      longint unsigned den;
      pose_res_t r;
      if (op) begin
        px = d[161:130]; py = d[193:162];
        hd = wrap_hd(longint'($signed(d[212:194])));
        vflag = 1;
        return;
      end
      cl = d[31:0]; cr = d[63:32];
      rl = longint'($signed(d[95:64])); rr = longint'($signed(d[127:96]));
      if (inv_l) begin
        cl = -cl; rl = -rl;
      end
      if (inv_r) begin
        cr = -cr; rr = -rr;
      end
      if (d[128] || d[129]) vflag = 0;
      wc = (longint'(radius) * 32768) / (longint'(rcorr) + 16384);
      dl = ((longint'($signed(last_l)) - longint'($signed(cl))) * wc) >>> 16;
      dr = ((longint'($signed(last_r)) - longint'($signed(cr))) * wc) >>> 16;
      last_l = cl; last_r = cr;
      mean = (dl + dr) >>> 1;
      den = longint'(sep) * longint'(scorr);
      hd = wrap_hd(hd + ratio(dl - dr, den, 64'd1 << 20));
      sincos(hd * 16384, c, s);
      px += 32'((mean * c) >>> 16);
      py += 32'((mean * s) >>> 16);
      sincos(hd * 8192, qc, qs);
      sl = (rl * wc) >>> 16;
      sr = (rr * wc) >>> 16;
      lin = clip((sl + sr) >>> 1, -64'sd2147483648, 64'sd2147483647);
      ang = clip(ratio(sl - sr, den, 64'd1 << 31), -64'sd2147483648, 64'sd2147483647);
      r.pos_x = px; r.pos_y = py; r.heading = 19'(hd);
      r.quat_w = 18'(qc); r.quat_z = 18'(qs);
      r.linear_speed = 32'(lin); r.angular_speed = 32'(ang);
      r.valid_res = vflag;
      pending_q.push_back(r);
    endfunction

    function void cmp(string name, bit [31:0] e, bit [31:0] a);
      if (e !== a) begin
        $error("%s: expected %h, got %h", name, e, a);
        errors++;
      end
    endfunction

    // Check one accepted result transfer against the oldest pose
    function void check_result(bit [183:0] raw);
      pose_res_t a, e;
      a = raw;
      if (pending_q.size() == 0) begin
        $error("result with no pending pose: %h", raw);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      cmp("pos_x", e.pos_x, a.pos_x);
      cmp("pos_y", e.pos_y, a.pos_y);
      cmp("heading", e.heading, a.heading);
      cmp("quat_w", e.quat_w, a.quat_w);
      cmp("quat_z", e.quat_z, a.quat_z);
      cmp("linear_speed", e.linear_speed, a.linear_speed);
      cmp("angular_speed", e.angular_speed, a.angular_speed);
      cmp("valid_res", e.valid_res, a.valid_res);
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic [0:0]   in_tuser = 0;
  logic [215:0] in_tdata = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [183:0] out_tdata;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic         cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  odo_scoreboard sb = new();
  bit quiet = 0;
  int n_ticks = 0, n_poses = 0, n_settings = 0;
  bit [31:0] run_l = 0, run_r = 0;

  differential_drive_odometry uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function bit stall();
    return !quiet && ($urandom_range(0, 99) < 22);
  endfunction

  // Receiver: check each result transfer, stall at random unless quiet is set
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= !stall();
  end

  task automatic send(bit op, bit [31:0] al, ar, rl, rr, bit fl, fr,
                      bit [31:0] nx, ny, bit [18:0] nh);
    int gaps = 0;
    while (stall()) gaps++;
    if (gaps > 0) begin
      in_tvalid <= 0;
      repeat (gaps) @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {3'b0, nh, ny, nx, fr, fl, rr, rl, ar, al};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, {3'b0, nh, ny, nx, fr, fl, rr, rl, ar, al});
    if (op) n_poses++; else n_ticks++;
  endtask

  task automatic tick(bit [31:0] al, ar, rl, rr, bit fl = 0, bit fr = 0);
    send(0, al, ar, rl, rr, fl, fr, $urandom, $urandom, 19'($urandom));
  endtask

  task automatic pose(bit [31:0] nx, ny, bit [18:0] nh);
    send(1, $urandom, $urandom, $urandom, $urandom, 1'($urandom), 1'($urandom),
         nx, ny, nh);
  endtask

  // Drop valid and wait out pending poses
  task automatic drain();
    int waited = 0;
    in_tvalid <= 0;
    while (sb.pending_q.size() > 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, bit [15:0] v);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= {16'h0, v};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(bit il, ir, bit [15:0] rad, rc, sp, sc);
    apb_write(REG_INV_L, il);
    apb_write(REG_INV_R, ir);
    apb_write(REG_RADIUS, rad);
    apb_write(REG_RCORR, rc);
    apb_write(REG_SEP, sp);
    apb_write(REG_SCORR, sc);
    @(posedge clk);
    n_settings++;
  endtask

  // Mostly smooth wheel motion, some jumps, some pose loads
  task automatic random_items(int count);
    bit [31:0] rl, rr;
    repeat (count) begin
      if ($urandom_range(0, 99) < 12) begin
        pose($urandom, $urandom, 19'($urandom_range(0, 411774) - 205887));
      end else begin
        if ($urandom_range(0, 99) < 10) begin
          run_l = $urandom; run_r = $urandom;
        end else begin
          run_l += $urandom_range(0, 8000) - 4000;
          run_r += $urandom_range(0, 8000) - 4000;
        end
        if ($urandom_range(0, 3) == 0) begin
          rl = $urandom; rr = $urandom;
        end else begin
          rl = $urandom_range(0, 1 << 20) - (1 << 19);
          rr = $urandom_range(0, 1 << 20) - (1 << 19);
        end
        tick(run_l, run_r, rl, rr, $urandom_range(0, 99) < 4,
             $urandom_range(0, 99) < 4);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, faults, pose loads, heading wrap
    configure(0, 0, 32768, 16384, 20000, 16384);
    tick(0, 0, 0, 0);
    tick(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    tick(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    tick(32'h00010000, 32'hffff0000, 32'h00010000, 32'h00010000, 1, 0);
    tick(32'h00020000, 32'hfffe0000, 0, 0, 0, 1);
    pose(32'h7fffffff, 32'h80000000, 19'sd205887);
    tick(32'h00030000, 32'hfffd0000, 32'hffffffff, 1);
    pose(32'h80000000, 32'h7fffffff, -19'sd205887);
    tick(32'h00030000, 32'hfffe0000, 0, 0);
    pose(0, 0, 19'sd200000);
    tick(32'hfff00000, 32'h00100000, 5, 7);
    pose(32'hffffffff, 0, -19'sd200000);
    tick(32'h00100000, 32'hfff00000, 32'hffffffff, 32'hffffffff, 1, 1);
    tick(32'h00100000, 32'hfff00000, 0, 0);
    drain();

    // Inversion with full-scale wheel angle
    configure(1, 1, 65535, 0, 65535, 65535);
    tick(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    tick(32'h7fffffff, 32'h00000001, 32'h7fffffff, 32'h80000000);
    random_items(60);
    drain();

    // Zero divisor: no turning terms
    configure(0, 1, 40000, 65535, 0, 16384);
    random_items(60);
    drain();
    configure(1, 0, 0, 0, 1000, 0);
    random_items(40);
    drain();

    quiet = 1;
    configure(0, 0, 6554, 16384, 13107, 16384);
    random_items(100);
    drain();
    quiet = 0;

    configure(1, 1, 65535, 65535, 1, 1);
    random_items(60);
    drain();

    repeat (2) begin
      configure(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
      random_items(80);
      drain();
    end

    if (sb.pending_q.size() > 0) begin
      $error("%0d poses never arrived", sb.pending_q.size());
      sb.errors++;
    end
    $display("Ran %0d ticks and %0d pose loads across %0d register settings.",
             n_ticks, n_poses, n_settings);
    if (sb.errors == 0) $display("differential_drive_odometry_tb: PASS");
    else $display("differential_drive_odometry_tb: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("differential_drive_odometry_tb: FAIL");
    $finish;
  end

endmodule

// ===== differential_drive_odometry.f =====
+incdir+rtl
rtl/odo_pkg.sv
rtl/odo_ctrl.sv
rtl/odo_dp.sv
rtl/differential_drive_odometry.sv
bench/differential_drive_odometry_tb.sv
